// ===== hdl/sstf_pkg.sv =====
// sstf_pkg: shared widths, register map, beat types and helpers for the
// shortest-seek-first disk request scheduler
// no dependencies
package sstf_pkg;

  localparam int unsigned MAX_REQ  = 32;
  localparam int unsigned IDX_W    = $clog2(MAX_REQ);
  localparam int unsigned CNT_W    = $clog2(MAX_REQ + 1);
  localparam int unsigned POS_W    = 16;
  localparam int unsigned SPT_W    = 10;
  localparam int unsigned RPM_W    = 14;
  localparam int unsigned MS_W     = 8;
  localparam int unsigned DEN_W    = SPT_W + RPM_W;
  localparam int unsigned SEEK_W   = 24;
  localparam int unsigned ROT_W    = 23;
  localparam int unsigned DIV_W    = 25;
  localparam int unsigned STEP_W   = $clog2(DIV_W + 1);
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // divider passes: a position needs 16 steps, the latency ratio the full width
  localparam int unsigned POS_STEPS = POS_W;
  localparam int unsigned ROT_STEPS = DIV_W;

  // 2 * 100 * 60, the doubled scale used for round-to-nearest
  localparam logic [13:0] ROT_SCALE = 14'd12000;

  // register indices (paddr[3:2])
  localparam logic [1:0] REG_SPT   = 2'd0;
  localparam logic [1:0] REG_RPM   = 2'd1;
  localparam logic [1:0] REG_SEEK  = 2'd2;
  localparam logic [1:0] REG_START = 2'd3;

  // reset values
  localparam logic [SPT_W-1:0] SPT_RST   = 10'd100;
  localparam logic [RPM_W-1:0] RPM_RST   = 14'd72;
  localparam logic [MS_W-1:0]  SEEK_RST  = 8'd2;
  localparam logic [POS_W-1:0] START_RST = 16'd100;

  typedef struct packed {
    logic [POS_W-1:0] request_position;
    logic             last_request;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0]  served_position;
    logic [IDX_W-1:0]  served_index;
    logic [SEEK_W-1:0] seek_time_ms;
    logic [ROT_W-1:0]  rotation_hundredths;
    logic              last_result;
  } res_t;

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== hdl/sstf_div.sv =====
// sstf_div: radix-2 restoring divider, one quotient bit per cycle
// shared by the track/sector split and the rotational latency ratio; uses sstf_pkg
module sstf_div import sstf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             short_i,     // 16-bit dividend, 16 steps
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o,
  output logic [DIV_W-1:0] rem_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]  dvs_q, dvs_d;
  logic [DIV_W:0]    shifted;
  logic              fits;

  // remainder stays below the divisor, so DIV_W bits hold it between steps
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = '0;
      dvs_d  = divisor_i;
      if (short_i) begin
        // left-align so the leading zero bits are skipped
        quo_d = dividend_i << (DIV_W - POS_STEPS);
        cnt_d = STEP_W'(POS_STEPS);
      end else begin
        quo_d = dividend_i;
        cnt_d = STEP_W'(ROT_STEPS);
      end
    end else if (busy_q) begin
      rem_d = fits ? DIV_W'(shifted - {1'b0, dvs_q}) : shifted[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/sstf_disk_request_scheduler.sv =====
// sstf_disk_request_scheduler: top level of the shortest-seek-first scheduler
// holds the request store, scan sequencer and config registers; uses sstf_pkg, sstf_div
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+------------------------------
//  request  | start, busy (beat: start & !busy) | req_i  (position, last flag)
//  result   | res_valid_o, one-cycle strobe    | res_o  (pos, index, seek, rot)
//  config   | apb: psel/penable/pwrite, pready | paddr/pwdata/prdata, 4 regs
//
//  a request beat without the last flag is stored while the store has room;
//  busy stays low. a last beat starts service: the divider splits the head
//  position, then each served request takes a scan through the loaded
//  requests (one entry per cycle) and two passes of the shared
//  one-bit-per-cycle divider (16 steps for track/sector, 25 for latency)
//  results go out as one-cycle strobes; the receiver cannot stall them
//  reset is asynchronous, active low; no clearing pass is needed
module sstf_disk_request_scheduler import sstf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  // result channel
  output logic              res_valid_o,
  output res_t              res_o,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;  // launch head split
  localparam logic [2:0] S_HEAD   = 3'd2;  // wait for head track/sector
  localparam logic [2:0] S_SCAN   = 3'd3;  // nearest-unserved search
  localparam logic [2:0] S_PSTART = 3'd4;  // launch pick split
  localparam logic [2:0] S_PDIV   = 3'd5;  // wait for pick track/sector
  localparam logic [2:0] S_SEEK   = 3'd6;  // seek product, launch latency division
  localparam logic [2:0] S_RDIV   = 3'd7;  // latency division, then emit

  // ---------------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------------
  logic [SPT_W-1:0] spt_q;
  logic [RPM_W-1:0] rpm_q;
  logic [MS_W-1:0]  ms_q;
  logic [POS_W-1:0] start_pos_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q       <= SPT_RST;
      rpm_q       <= RPM_RST;
      ms_q        <= SEEK_RST;
      start_pos_q <= START_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SPT:   spt_q       <= pwdata[SPT_W-1:0];
        REG_RPM:   rpm_q       <= pwdata[RPM_W-1:0];
        REG_SEEK:  ms_q        <= pwdata[MS_W-1:0];
        REG_START: start_pos_q <= pwdata[POS_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SPT:   prdata = DATA_W'(spt_q);
      REG_RPM:   prdata = DATA_W'(rpm_q);
      REG_SEEK:  prdata = DATA_W'(ms_q);
      REG_START: prdata = DATA_W'(start_pos_q);
      default:   prdata = '0;
    endcase
  end

  // zero divisors count as one
  logic [SPT_W-1:0] spt_eff;
  logic [RPM_W-1:0] rpm_eff;
  assign spt_eff = (spt_q == '0) ? SPT_W'(1) : spt_q;
  assign rpm_eff = (rpm_q == '0) ? RPM_W'(1) : rpm_q;

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;        // requests loaded
  logic [CNT_W-1:0]  pick_q, pick_d;      // requests served in this batch
  logic [MAX_REQ-1:0] served_q, served_d;
  logic [POS_W-1:0]  head_pos_q, head_pos_d;
  logic [POS_W-1:0]  head_trk_q, head_trk_d;
  logic [SPT_W-1:0]  head_sec_q, head_sec_d;
  logic [DEN_W-1:0]  den_q, den_d;

  // scan pipeline: address stage then compare stage
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [POS_W-1:0]  best_pos_q, best_pos_d;
  logic [POS_W-1:0]  best_dist_q, best_dist_d;

  // pick arithmetic
  logic [POS_W-1:0]  pick_trk_q, pick_trk_d;
  logic [SPT_W-1:0]  pick_sec_q, pick_sec_d;
  logic [SEEK_W-1:0] seek_q, seek_d;
  logic [SPT_W-1:0]  sdiff_q, sdiff_d;

  // result register
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  // request store
  logic [POS_W-1:0]  store_mem [MAX_REQ];
  logic [POS_W-1:0]  store_rd_q;
  logic              store_we;
  logic [IDX_W-1:0]  store_wa;

  // shared divider
  logic              div_start, div_short, div_done;
  logic [DIV_W-1:0]  div_dividend, div_divisor, div_quot, div_rem;

  logic              accept;
  logic [POS_W-1:0]  cand_dist;
  logic [23:0]       rot_scaled;
  logic              batch_end;

  assign busy   = (state_q != S_IDLE);
  assign accept = start & ~busy;

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_wa] <= req_i.request_position;
    end
    store_rd_q <= store_mem[rd_idx_q[IDX_W-1:0]];
  end

  assign store_we = accept & (cnt_q < CNT_W'(MAX_REQ));
  assign store_wa = cnt_q[IDX_W-1:0];

  assign cand_dist  = abs_diff(head_pos_q, store_rd_q);
  assign rot_scaled = 24'(sdiff_q) * 24'(ROT_SCALE);
  assign batch_end  = (pick_q + CNT_W'(1)) == cnt_q;

  // divider operand select: latency ratio in S_SEEK, else a position split
  always_comb begin
    div_start    = 1'b0;
    div_short    = 1'b1;
    div_divisor  = DIV_W'(spt_eff);
    div_dividend = DIV_W'(head_pos_q);
    case (state_q)
      S_PREP:   div_start = 1'b1;
      S_PSTART: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(best_pos_q);
      end
      S_SEEK: begin
        // (2*6000*sdiff + den) / (2*den) rounds half up
        div_start    = 1'b1;
        div_short    = 1'b0;
        div_dividend = DIV_W'(rot_scaled) + DIV_W'(den_q);
        div_divisor  = {den_q, 1'b0};
      end
      default: ;
    endcase
  end

  sstf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .short_i    (div_short),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pick_d      = pick_q;
    served_d    = served_q;
    head_pos_d  = head_pos_q;
    head_trk_d  = head_trk_q;
    head_sec_d  = head_sec_q;
    den_d       = den_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_pos_d  = best_pos_q;
    best_dist_d = best_dist_q;
    pick_trk_d  = pick_trk_q;
    pick_sec_d  = pick_sec_q;
    seek_d      = seek_q;
    sdiff_d     = sdiff_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (store_we) begin
            served_d[store_wa] = 1'b0;
            cnt_d              = cnt_q + CNT_W'(1);
          end
          if (req_i.last_request) begin
            den_d      = DEN_W'(rpm_eff) * DEN_W'(spt_eff);
            head_pos_d = start_pos_q;
            pick_d     = '0;
            state_d    = S_PREP;
          end
        end
      end

      S_PREP: state_d = S_HEAD;

      S_HEAD: begin
        if (div_done) begin
          head_trk_d = div_quot[POS_W-1:0];
          head_sec_d = div_rem[SPT_W-1:0];
          rd_idx_d   = '0;
          found_d    = 1'b0;
          state_d    = S_SCAN;
        end
      end

      S_SCAN: begin
        if (rd_idx_q < cnt_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + CNT_W'(1);
        end
        if (cmp_vld_q) begin
          // strict less-than keeps the lowest index on a tie
          if (!served_q[cmp_idx_q] && (!found_q || cand_dist < best_dist_q)) begin
            found_d     = 1'b1;
            best_idx_d  = cmp_idx_q;
            best_pos_d  = store_rd_q;
            best_dist_d = cand_dist;
          end
          if (CNT_W'(cmp_idx_q) == cnt_q - CNT_W'(1)) begin
            state_d = S_PSTART;
          end
        end
      end

      S_PSTART: state_d = S_PDIV;

      S_PDIV: begin
        if (div_done) begin
          pick_trk_d = div_quot[POS_W-1:0];
          pick_sec_d = div_rem[SPT_W-1:0];
          state_d    = S_SEEK;
        end
      end

      S_SEEK: begin
        // sdiff_q is settled here from the previous cycle's pick split
        seek_d  = SEEK_W'(abs_diff(head_trk_q, pick_trk_q)) * SEEK_W'(ms_q);
        state_d = S_RDIV;
      end

      S_RDIV: begin
        if (div_done) begin
          res_valid_d               = 1'b1;
          res_d.served_position     = best_pos_q;
          res_d.served_index        = best_idx_q;
          res_d.seek_time_ms        = seek_q;
          res_d.rotation_hundredths = div_quot[ROT_W-1:0];
          res_d.last_result         = batch_end;
          served_d[best_idx_q]      = 1'b1;
          head_pos_d                = best_pos_q;
          head_trk_d                = pick_trk_q;
          head_sec_d                = pick_sec_q;
          pick_d                    = pick_q + CNT_W'(1);
          rd_idx_d                  = '0;
          found_d                   = 1'b0;
          if (batch_end) begin
            cnt_d   = '0;
            state_d = S_IDLE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase

    // sector distance is taken from the pick split remainder and registered with it
    if (state_q == S_PDIV && div_done) begin
      sdiff_d = SPT_W'(abs_diff(POS_W'(div_rem[SPT_W-1:0]), POS_W'(head_sec_q)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pick_q      <= '0;
      served_q    <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
      head_pos_q  <= START_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pick_q      <= pick_d;
      served_q    <= served_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      res_valid_q <= res_valid_d;
      head_pos_q  <= head_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_trk_q  <= head_trk_d;
    head_sec_q  <= head_sec_d;
    den_q       <= den_d;
    cmp_idx_q   <= cmp_idx_d;
    best_idx_q  <= best_idx_d;
    best_pos_q  <= best_pos_d;
    best_dist_q <= best_dist_d;
    pick_trk_q  <= pick_trk_d;
    pick_sec_q  <= pick_sec_d;
    seek_q      <= seek_d;
    sdiff_q     <= sdiff_d;
    res_q       <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/sstf_checker.sv =====
// sstf_checker: port-level timing checks for the scheduler top level
// bound to sstf_disk_request_scheduler; uses sstf_pkg
module sstf_checker import sstf_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic res_valid_o,
  input res_t res_o
);

  // a plain load beat leaves the block idle in the next cycle
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !req_i.last_request |=> !busy)
    else $error("load beat left the block busy");

  // a last beat always starts service
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.last_request |=> busy)
    else $error("last beat did not start service");

  // results are never back to back, each pick needs a fresh scan
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held for two cycles");

  // service continues after a result that is not the last one
  a_mid_batch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_result |-> busy)
    else $error("block idle in the middle of a batch");

  // the final result frees the block
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_result |-> !busy)
    else $error("block still busy after the final result");

endmodule

bind sstf_disk_request_scheduler sstf_checker u_sstf_checker (.*);
